// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/spr_pkg.sv =====
package spr_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int CHAN_W    = 2;
    localparam int SAMPLE_W  = 12;
    localparam int PINS_W    = 3;
    localparam int MODE_W    = 2;
    localparam int POS_OUT_W = 9;
    localparam int WIDTH_W   = 11;
    localparam int TICK_W    = 16;
    localparam int CFG_W     = 16;
    localparam int RF_W      = 10;
    localparam int NUM_CH    = 3;
    localparam int ENTRY_W   = NUM_CH * WIDTH_W;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_BUTTON = 2'd2
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_MANUAL   = 2'd0,
        MODE_RECORD   = 2'd1,
        MODE_PLAYBACK = 2'd2
    } mode_t;

    typedef enum logic {
        CFG_FRAME_PERIOD  = 1'b0,
        CFG_RECORD_FRAMES = 1'b1
    } cfg_idx_t;

    // reset values and the minimum pulse width
    localparam logic [TICK_W-1:0]  FRAME_PERIOD_RST  = 16'd20000;
    localparam logic [RF_W-1:0]    RECORD_FRAMES_RST = 10'd500;
    localparam logic [WIDTH_W-1:0] WIDTH_CENTER      = 11'd1500;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN         = 11'd1000;

    // pot mapping: deadband edges
    localparam logic [SAMPLE_W-1:0] DEAD_LO = 12'd1948;
    localparam logic [SAMPLE_W-1:0] DEAD_HI = 12'd2147;

    // x*500/d as x*(500*ceil(2^32/d)) >> 32, exact for x*500 < 2^20
    localparam int MAP_SHIFT = 32;
    localparam int MAP_MUL_W = 32;
    localparam int MAP_PROD_W = SAMPLE_W + MAP_MUL_W;
    localparam int MAP_Q_W   = 9;
    localparam logic [63:0] MAP_LO_RECIP = ((64'd1 << 32) + 64'd1946) / 64'd1947;
    localparam logic [63:0] MAP_HI_RECIP = ((64'd1 << 32) + 64'd1947) / 64'd1948;
    localparam logic [MAP_MUL_W-1:0] MAP_LO_MUL = MAP_MUL_W'(MAP_LO_RECIP * 64'd500);
    localparam logic [MAP_MUL_W-1:0] MAP_HI_MUL = MAP_MUL_W'(MAP_HI_RECIP * 64'd500);

    typedef struct packed {
        logic [PINS_W-1:0]    pins;
        mode_t                mode;
        logic [POS_OUT_W-1:0] pos;
        logic                 fs;
    } result_t;

endpackage

// ===== hw/rtl/spr_ram.sv =====
module spr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/servo_pwm_record_playback.sv =====
// channel | direction | handshake          | payload
// cfg     | in        | cfg_we             | cfg_index, cfg_data
// in      | in        | in_valid, in_stall | operation, channel, sample
// out     | out       | out_valid,out_stall| servo_pins, current_mode, ring_position, frame_start
//
// one item per cycle while in_stall is low; each item gives one result, held in the output buffer
// motion ring read is always issued at the next playback position,
// so a frame-start tick in playback finds its entry waiting in the ram output
// reset: no clearing pass; a fill count marks the recorded prefix of the ring
// in_stall rises only when both output register and skid stage hold a result
module servo_pwm_record_playback #(
    parameter int RING_DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [spr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [spr_pkg::OP_W-1:0]      operation,
    input  logic [spr_pkg::CHAN_W-1:0]    channel,
    input  logic [spr_pkg::SAMPLE_W-1:0]  sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [spr_pkg::PINS_W-1:0]    servo_pins,
    output logic [spr_pkg::MODE_W-1:0]    current_mode,
    output logic [spr_pkg::POS_OUT_W-1:0] ring_position,
    output logic                          frame_start
);

    // ring address width and a length width that holds both record_frames and the depth
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int LW = (CW > spr_pkg::RF_W) ? CW : spr_pkg::RF_W;

    typedef logic [spr_pkg::WIDTH_W-1:0] width_t;

    // ring length: zero means one, capped at the ring depth
    function automatic logic [LW-1:0] ring_len(input logic [spr_pkg::RF_W-1:0] rf);
        logic [LW-1:0] n;
        begin
            n = LW'(rf);
            if (rf == '0)
            begin
                n = LW'(1);
            end
            if (n > LW'(RING_DEPTH))
            begin
                n = LW'(RING_DEPTH);
            end
            return n;
        end
    endfunction

    // a position at or past the ring length restarts at zero
    function automatic logic [AW-1:0] wrap_pos(input logic [AW-1:0] pos,
                                               input logic [LW-1:0] n);
        return (LW'(pos) >= n) ? '0 : pos;
    endfunction

    function automatic logic [AW-1:0] adv_pos(input logic [AW-1:0] pos,
                                              input logic [LW-1:0] n);
        logic [LW-1:0] p1;
        begin
            p1 = LW'(pos) + LW'(1);
            return (p1 >= n) ? '0 : AW'(p1);
        end
    endfunction

    // configuration
    logic [spr_pkg::CFG_W-1:0]  frame_period_reg, frame_period_next;
    logic [spr_pkg::RF_W-1:0]   record_frames_reg, record_frames_next;

    // block state
    logic [spr_pkg::TICK_W-1:0] tick_count_reg, tick_count_next;
    width_t                     width0_reg, width0_next;
    width_t                     width1_reg, width1_next;
    width_t                     width2_reg, width2_next;
    spr_pkg::mode_t             mode_reg, mode_next;
    logic [AW-1:0]              record_pos_reg, record_pos_next;
    logic [AW-1:0]              play_pos_reg, play_pos_next;
    logic [spr_pkg::PINS_W-1:0] pins_reg, pins_next;
    logic [LW-1:0]              fill_reg, fill_next;

    // ring access
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [spr_pkg::ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [spr_pkg::ENTRY_W-1:0] mem_rdata;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        bypass_hit_reg, bypass_hit_next;
    logic [spr_pkg::ENTRY_W-1:0] bypass_data_reg;
    logic [spr_pkg::ENTRY_W-1:0] play_entry;

    // output register and skid stage
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    spr_pkg::result_t out_data_reg, out_data_next;
    spr_pkg::result_t skid_data_reg, skid_data_next;
    spr_pkg::result_t result;

    // pot mapping
    logic [spr_pkg::MAP_PROD_W-1:0] lo_prod;
    logic [spr_pkg::MAP_PROD_W-1:0] hi_prod;
    logic [spr_pkg::SAMPLE_W-1:0]   hi_diff;
    width_t                         map_width;

    logic          accept;
    logic          out_take;
    logic          fs;
    logic [LW-1:0] ring_n;
    logic [LW-1:0] ring_n_next;
    logic [AW-1:0] cur_pos;
    logic [LW-1:0] wr_end;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign ring_n = ring_len(record_frames_reg);

    // sample to width, deadband around the center
    assign hi_diff = sample - spr_pkg::DEAD_HI;
    assign lo_prod = spr_pkg::MAP_PROD_W'(sample) * spr_pkg::MAP_PROD_W'(spr_pkg::MAP_LO_MUL);
    assign hi_prod = spr_pkg::MAP_PROD_W'(hi_diff) * spr_pkg::MAP_PROD_W'(spr_pkg::MAP_HI_MUL);

    always_comb
    begin
        if (sample < spr_pkg::DEAD_LO)
        begin
            map_width = spr_pkg::WIDTH_MIN + spr_pkg::WIDTH_W'(
                lo_prod[spr_pkg::MAP_SHIFT +: spr_pkg::MAP_Q_W]);
        end
        else if (sample < spr_pkg::DEAD_HI)
        begin
            map_width = spr_pkg::WIDTH_CENTER;
        end
        else
        begin
            map_width = spr_pkg::WIDTH_CENTER + spr_pkg::WIDTH_W'(
                hi_prod[spr_pkg::MAP_SHIFT +: spr_pkg::MAP_Q_W]);
        end
    end

    // entry prefetched last cycle, with the same-cycle write forwarded
    assign play_entry = bypass_hit_reg ? bypass_data_reg : mem_rdata;

    // config decode
    always_comb
    begin
        frame_period_next  = frame_period_reg;
        record_frames_next = record_frames_reg;
        if (cfg_we)
        begin
            unique case (spr_pkg::cfg_idx_t'(cfg_index))
                spr_pkg::CFG_FRAME_PERIOD:  frame_period_next  = cfg_data;
                spr_pkg::CFG_RECORD_FRAMES: record_frames_next = cfg_data[spr_pkg::RF_W-1:0];
                default: ;
            endcase
        end
    end

    // item execution
    always_comb
    begin
        tick_count_next = tick_count_reg;
        width0_next     = width0_reg;
        width1_next     = width1_reg;
        width2_next     = width2_reg;
        mode_next       = mode_reg;
        record_pos_next = record_pos_reg;
        play_pos_next   = play_pos_reg;
        pins_next       = pins_reg;
        mem_we          = 1'b0;
        mem_waddr       = wrap_pos(record_pos_reg, ring_n);
        mem_wdata       = {width2_reg, width1_reg, width0_reg};
        fs              = 1'b0;
        cur_pos         = wrap_pos(play_pos_reg, ring_n);

        if (accept)
        begin
            case (spr_pkg::op_t'(operation))
                spr_pkg::OP_SAMPLE:
                begin
                    if (mode_reg != spr_pkg::MODE_PLAYBACK)
                    begin
                        case (channel)
                            2'd0:    width0_next = map_width;
                            2'd1:    width1_next = map_width;
                            2'd2:    width2_next = map_width;
                            default: ;  // no fourth servo
                        endcase
                    end
                end
                spr_pkg::OP_TICK:
                begin
                    if (tick_count_reg == '0)
                    begin
                        // frame start: all pins high, one ring access in record or playback
                        fs        = 1'b1;
                        pins_next = '1;
                        if (mode_reg == spr_pkg::MODE_RECORD)
                        begin
                            mem_we          = 1'b1;
                            record_pos_next = adv_pos(mem_waddr, ring_n);
                        end
                        else if (mode_reg == spr_pkg::MODE_PLAYBACK)
                        begin
                            // entries past the recorded prefix read as zero
                            if (rd_valid_reg)
                            begin
                                width0_next = play_entry[0 +: spr_pkg::WIDTH_W];
                                width1_next = play_entry[spr_pkg::WIDTH_W +: spr_pkg::WIDTH_W];
                                width2_next = play_entry[2*spr_pkg::WIDTH_W +: spr_pkg::WIDTH_W];
                            end
                            else
                            begin
                                width0_next = '0;
                                width1_next = '0;
                                width2_next = '0;
                            end
                            play_pos_next = adv_pos(cur_pos, ring_n);
                        end
                    end
                    // a pin drops on the tick that matches its width
                    if (spr_pkg::TICK_W'(width0_next) == tick_count_reg)
                    begin
                        pins_next[0] = 1'b0;
                    end
                    if (spr_pkg::TICK_W'(width1_next) == tick_count_reg)
                    begin
                        pins_next[1] = 1'b0;
                    end
                    if (spr_pkg::TICK_W'(width2_next) == tick_count_reg)
                    begin
                        pins_next[2] = 1'b0;
                    end
                    if ((17'(tick_count_reg) + 17'd1) >= 17'(frame_period_reg))
                    begin
                        tick_count_next = '0;
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + spr_pkg::TICK_W'(1);
                    end
                end
                spr_pkg::OP_BUTTON:
                begin
                    // manual -> record -> playback -> manual
                    if (mode_reg == spr_pkg::MODE_MANUAL)
                    begin
                        mode_next       = spr_pkg::MODE_RECORD;
                        record_pos_next = '0;
                    end
                    else if (mode_reg == spr_pkg::MODE_RECORD)
                    begin
                        mode_next     = spr_pkg::MODE_PLAYBACK;
                        play_pos_next = '0;
                    end
                    else
                    begin
                        mode_next = spr_pkg::MODE_MANUAL;
                    end
                end
                default: ;  // unused opcode
            endcase
        end
    end

    // recorded prefix grows one entry at a time
    assign wr_end = LW'(mem_waddr) + LW'(1);
    assign fill_next = (mem_we && (wr_end > fill_reg)) ? wr_end : fill_reg;

    // prefetch the entry the next playback frame will use
    assign ring_n_next     = ring_len(record_frames_next);
    assign mem_raddr       = wrap_pos(play_pos_next, ring_n_next);
    assign rd_valid_next   = LW'(mem_raddr) < fill_next;
    assign bypass_hit_next = mem_we && (mem_waddr == mem_raddr);

    // result of this item
    always_comb
    begin
        result.pins = pins_next;
        result.mode = mode_next;
        result.pos  = (mode_next == spr_pkg::MODE_RECORD) ?
                      spr_pkg::POS_OUT_W'(record_pos_next) :
                      spr_pkg::POS_OUT_W'(play_pos_next);
        result.fs   = fs;
    end

    // two-entry output buffer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    spr_ram #(
        .WIDTH (spr_pkg::ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_motion_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg  <= spr_pkg::FRAME_PERIOD_RST;
            record_frames_reg <= spr_pkg::RECORD_FRAMES_RST;
            tick_count_reg    <= '0;
            width0_reg        <= spr_pkg::WIDTH_CENTER;
            width1_reg        <= spr_pkg::WIDTH_CENTER;
            width2_reg        <= spr_pkg::WIDTH_CENTER;
            mode_reg          <= spr_pkg::MODE_MANUAL;
            record_pos_reg    <= '0;
            play_pos_reg      <= '0;
            pins_reg          <= '0;
            fill_reg          <= '0;
            rd_valid_reg      <= 1'b0;
            bypass_hit_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_period_reg  <= frame_period_next;
            record_frames_reg <= record_frames_next;
            tick_count_reg    <= tick_count_next;
            width0_reg        <= width0_next;
            width1_reg        <= width1_next;
            width2_reg        <= width2_next;
            mode_reg          <= mode_next;
            record_pos_reg    <= record_pos_next;
            play_pos_reg      <= play_pos_next;
            pins_reg          <= pins_next;
            fill_reg          <= fill_next;
            rd_valid_reg      <= rd_valid_next;
            bypass_hit_reg    <= bypass_hit_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        bypass_data_reg <= mem_wdata;
        out_data_reg    <= out_data_next;
        skid_data_reg   <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign servo_pins    = out_data_reg.pins;
    assign current_mode  = out_data_reg.mode;
    assign ring_position = out_data_reg.pos;
    assign frame_start   = out_data_reg.fs;

endmodule

// ===== hw/rtl/spr_checker.sv =====
`include "assert_macros.svh"

module spr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_we,
    input logic                          cfg_index,
    input logic [spr_pkg::CFG_W-1:0]     cfg_data,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [spr_pkg::OP_W-1:0]      operation,
    input logic [spr_pkg::CHAN_W-1:0]    channel,
    input logic [spr_pkg::SAMPLE_W-1:0]  sample,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [spr_pkg::PINS_W-1:0]    servo_pins,
    input logic [spr_pkg::MODE_W-1:0]    current_mode,
    input logic [spr_pkg::POS_OUT_W-1:0] ring_position,
    input logic                          frame_start
);

    // every accepted item shows a result the next cycle
    `SPR_ASSERT_NEXT(a_item_result, in_valid && !in_stall, out_valid)

    // the input only stalls while a result is already waiting
    `SPR_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid)

    // a drained output frees the input as soon as the skid result moves up to the output register
    `SPR_ASSERT_NEXT(a_stall_clears, in_stall && !out_stall, !in_stall)

    // a held result stays offered and unchanged
    `SPR_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)
    `SPR_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(servo_pins) && $stable(current_mode) && $stable(ring_position) && $stable(frame_start))

endmodule

bind servo_pwm_record_playback spr_checker u_spr_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import spr_pkg::*;

    // codes outside the package enums: reserved operation, channel three
    localparam logic [OP_W-1:0]   OP_RESERVED = 2'd3;
    localparam logic [CHAN_W-1:0] CHAN_NONE   = 2'd3;
    localparam int RING_SLOTS      = 512;
    localparam int SHORT_FRAME_ROW = 16;

    // one row of the opening table; want is used only where known is set
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] s;
        logic                known;
        result_t             want;
    } stim_row_t;

    // one stretch of random traffic under one timing setting
    typedef struct {
        logic [TICK_W-1:0] period;
        logic [RF_W-1:0]   frames;
        int unsigned       items;
        mode_t             start;
        int unsigned       btn_pm;
        int unsigned       smp_pm;
        int unsigned       noise_pm;
    } phase_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic                 cfg_index  = CFG_FRAME_PERIOD;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation  = OP_SAMPLE;
    logic [CHAN_W-1:0]    channel    = '0;
    logic [SAMPLE_W-1:0]  sample     = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [PINS_W-1:0]    servo_pins;
    logic [MODE_W-1:0]    current_mode;
    logic [POS_OUT_W-1:0] ring_position;
    logic                 frame_start;

    servo_pwm_record_playback uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .channel       (channel),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .servo_pins    (servo_pins),
        .current_mode  (current_mode),
        .ring_position (ring_position),
        .frame_start   (frame_start)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // the run must never get near this; it only catches a hung handshake
    initial
    begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // shadow copy of the servo state, advanced once per accepted item
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]    shadow_ticks;
    logic [WIDTH_W-1:0]   shadow_width [NUM_CH];
    mode_t                shadow_mode;
    logic [8:0]           shadow_rec_pos;
    logic [8:0]           shadow_play_pos;
    logic [PINS_W-1:0]    shadow_pins;
    logic [ENTRY_W-1:0]   shadow_ring [RING_SLOTS];
    logic [TICK_W-1:0]    shadow_period;
    logic [RF_W-1:0]      shadow_frames;

    result_t     servo_status_due [$];   // predicted status, oldest first
    int unsigned mismatch_count = 0;
    int unsigned steady_left    = 0;     // items left in a gap-free stretch

    // pot reading to pulse width: linear on both sides of the deadband
    function automatic logic [WIDTH_W-1:0] pot_to_width(logic [SAMPLE_W-1:0] s);
        int unsigned v;
        v = s;
        if (v < DEAD_LO)
            return WIDTH_W'(1000 + v * 500 / 1947);
        if (v < DEAD_HI)
            return WIDTH_CENTER;
        return WIDTH_W'(1500 + (v - DEAD_HI) * 500 / 1948);
    endfunction

    // frame-start bookkeeping: raise all pins, then record or reload a ring entry
    function automatic void start_frame();
        int unsigned n;
        int k;
        n = (shadow_frames == 0) ? 1 : shadow_frames;
        if (n > RING_SLOTS)
            n = RING_SLOTS;
        shadow_pins = '1;
        if (shadow_mode == MODE_RECORD)
        begin
            if (shadow_rec_pos >= n)
                shadow_rec_pos = '0;
            for (k = 0; k < NUM_CH; k++)
                shadow_ring[shadow_rec_pos][k*WIDTH_W +: WIDTH_W] = shadow_width[k];
            shadow_rec_pos = (shadow_rec_pos + 1 >= n) ? 9'd0 : shadow_rec_pos + 9'd1;
        end
        else if (shadow_mode == MODE_PLAYBACK)
        begin
            if (shadow_play_pos >= n)
                shadow_play_pos = '0;
            for (k = 0; k < NUM_CH; k++)
                shadow_width[k] = shadow_ring[shadow_play_pos][k*WIDTH_W +: WIDTH_W];
            shadow_play_pos = (shadow_play_pos + 1 >= n) ? 9'd0 : shadow_play_pos + 9'd1;
        end
    endfunction

    function automatic result_t predict_servo_status(logic [OP_W-1:0] op,
                                                     logic [CHAN_W-1:0] ch,
                                                     logic [SAMPLE_W-1:0] s);
        result_t r;
        int unsigned nxt;
        int k;
        r = '0;
        case (op)
            OP_SAMPLE:
            begin
                // playback owns the widths; channel three goes nowhere
                if (shadow_mode != MODE_PLAYBACK && ch < NUM_CH)
                    shadow_width[ch] = pot_to_width(s);
            end
            OP_TICK:
            begin
                if (shadow_ticks == 0)
                begin
                    r.fs = 1'b1;
                    start_frame();
                end
                // a width already passed keeps its pin high until next frame
                for (k = 0; k < NUM_CH; k++)
                    if (shadow_width[k] == shadow_ticks)
                        shadow_pins[k] = 1'b0;
                nxt = shadow_ticks + 1;
                shadow_ticks = (nxt >= shadow_period) ? '0 : TICK_W'(nxt);
            end
            OP_BUTTON:
            begin
                case (shadow_mode)
                    MODE_MANUAL:
                    begin
                        shadow_mode    = MODE_RECORD;
                        shadow_rec_pos = '0;
                    end
                    MODE_RECORD:
                    begin
                        shadow_mode     = MODE_PLAYBACK;
                        shadow_play_pos = '0;
                    end
                    default: shadow_mode = MODE_MANUAL;
                endcase
            end
            default: ;  // reserved operation does nothing
        endcase
        r.pins = shadow_pins;
        r.mode = shadow_mode;
        r.pos  = (shadow_mode == MODE_RECORD) ? shadow_rec_pos : shadow_play_pos;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // random hold-off before the next item: mostly none, some short, a few long,
    // and now and then a long run with no gaps at all
    task automatic idle_sender();
        int unsigned gap;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else if (roll < 4)
        begin
            steady_left = $urandom_range(20, 60);
            gap = 0;
        end
        else if (roll < 65)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(6, 20);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // present one item and hold it until the block takes it; stall is read
    // at the falling edge, where it already has its value for the next edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                             input logic [SAMPLE_W-1:0] s, input logic known,
                             input result_t want);
        result_t r;
        in_valid  <= 1'b1;
        operation <= op;
        channel   <= ch;
        sample    <= s;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        // predictor always runs so its state stays in step with the block
        r = predict_servo_status(op, ch, s);
        servo_status_due.push_back(known ? want : r);
    endtask

    // sample values lean toward the range ends and the deadband edges
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return DEAD_LO - 12'd1;
            3:       return DEAD_LO;
            4:       return DEAD_HI - 12'd1;
            5:       return DEAD_HI;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // one random item; counted is low for items the block just ignores
    task automatic send_random(input int unsigned btn_pm, input int unsigned smp_pm,
                               input int unsigned noise_pm, output logic counted);
        int unsigned roll;
        logic [SAMPLE_W-1:0] s;
        roll    = $urandom_range(0, 999);
        s       = pick_sample();
        counted = 1'b1;
        if (roll < btn_pm)
            send_item(OP_BUTTON, CHAN_W'($urandom), s, 1'b0, '0);
        else if (roll < btn_pm + smp_pm)
            send_item(OP_SAMPLE, CHAN_W'($urandom_range(0, NUM_CH - 1)), s, 1'b0, '0);
        else if (roll < btn_pm + smp_pm + noise_pm)
        begin
            counted = 1'b0;
            if ($urandom_range(0, 1))
                send_item(OP_RESERVED, CHAN_W'($urandom), s, 1'b0, '0);
            else
                send_item(OP_SAMPLE, CHAN_NONE, s, 1'b0, '0);
        end
        else
            send_item(OP_TICK, CHAN_W'($urandom), s, 1'b0, '0);
    endtask

    // press the button until the shadow copy says we are in the wanted mode
    task automatic steer_mode(input mode_t target);
        while (shadow_mode != target)
        begin
            idle_sender();
            send_item(OP_BUTTON, '0, '0, 1'b0, '0);
        end
    endtask

    // timing registers change only with nothing in flight; the pause lets the
    // ring prefetch settle before the write
    task automatic set_timing(input logic [TICK_W-1:0] period, input logic [RF_W-1:0] frames);
        in_valid <= 1'b0;
        while (servo_status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        shadow_period = period;
        // upper data bits are junk that the ring length register drops
        cfg_index <= CFG_RECORD_FRAMES;
        cfg_data  <= {6'($urandom), frames};
        @(posedge clk);
        shadow_frames = frames;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stall runs, mostly short, a few long, with
    // stall-free stretches, mostly short and now and then long, in between
    // ------------------------------------------------------------------
    initial
    begin : receiver_stall
        int unsigned run_len;
        logic stalling;
        run_len  = 0;
        stalling = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (run_len == 0)
            begin
                stalling = !stalling;
                if (stalling)
                    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                          : $urandom_range(1, 3);
                else
                    run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 8);
            end
            out_stall <= stalling;
            run_len--;
        end
    end

    // results are stable between edges, so the one taken at the next edge is
    // checked at the falling edge before it
    always @(negedge clk)
    begin : status_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (servo_status_due.size() == 0)
            begin
                $display("%0t: result with nothing expected (pins %0d mode %0d pos %0d fs %0d)",
                         $time, servo_pins, current_mode, ring_position, frame_start);
                mismatch_count++;
            end
            else
            begin
                want = servo_status_due.pop_front();
                if (servo_pins !== want.pins)
                begin
                    $display("%0t: servo_pins expected %0d, got %0d",
                             $time, want.pins, servo_pins);
                    mismatch_count++;
                end
                if (current_mode !== want.mode)
                begin
                    $display("%0t: current_mode expected %0d, got %0d",
                             $time, want.mode, current_mode);
                    mismatch_count++;
                end
                if (ring_position !== want.pos)
                begin
                    $display("%0t: ring_position expected %0d, got %0d",
                             $time, want.pos, ring_position);
                    mismatch_count++;
                end
                if (frame_start !== want.fs)
                begin
                    $display("%0t: frame_start expected %0d, got %0d",
                             $time, want.fs, frame_start);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // opening table: range ends, deadband edges, every operation, ignored
    // channel and operation, then (after the timing change) a one-tick frame
    // with a three-entry ring, so playback runs into never-recorded entries
    // and their zero widths drop the pins on the frame-start tick itself
    // ------------------------------------------------------------------
    stim_row_t opening_rows [24] = '{
        '{OP_SAMPLE,   2'd0,      12'd0,    1'b1, '{3'd0, MODE_MANUAL,   9'd0, 1'b0}},
        '{OP_SAMPLE,   2'd1,      12'd4095, 1'b1, '{3'd0, MODE_MANUAL,   9'd0, 1'b0}},
        '{OP_SAMPLE,   2'd2,      12'd1947, 1'b0, '0},
        '{OP_SAMPLE,   2'd2,      12'd1948, 1'b0, '0},
        '{OP_SAMPLE,   2'd0,      12'd2146, 1'b0, '0},
        '{OP_SAMPLE,   2'd0,      12'd2147, 1'b0, '0},
        '{OP_SAMPLE,   CHAN_NONE, 12'd4095, 1'b1, '{3'd0, MODE_MANUAL,   9'd0, 1'b0}},
        '{OP_RESERVED, 2'd0,      12'd4095, 1'b1, '{3'd0, MODE_MANUAL,   9'd0, 1'b0}},
        '{OP_TICK,     2'd0,      12'd0,    1'b1, '{3'd7, MODE_MANUAL,   9'd0, 1'b1}},
        '{OP_TICK,     2'd0,      12'd0,    1'b1, '{3'd7, MODE_MANUAL,   9'd0, 1'b0}},
        '{OP_BUTTON,   2'd0,      12'd0,    1'b1, '{3'd7, MODE_RECORD,   9'd0, 1'b0}},
        '{OP_SAMPLE,   2'd1,      12'd2048, 1'b0, '0},
        '{OP_BUTTON,   2'd0,      12'd0,    1'b1, '{3'd7, MODE_PLAYBACK, 9'd0, 1'b0}},
        '{OP_SAMPLE,   2'd0,      12'd0,    1'b1, '{3'd7, MODE_PLAYBACK, 9'd0, 1'b0}},
        '{OP_BUTTON,   2'd0,      12'd0,    1'b1, '{3'd7, MODE_MANUAL,   9'd0, 1'b0}},
        '{OP_SAMPLE,   2'd1,      12'd1,    1'b0, '0},
        // frame length 1, ring of 3 from here on
        '{OP_BUTTON,   2'd0,      12'd0,    1'b1, '{3'd7, MODE_RECORD,   9'd0, 1'b0}},
        '{OP_TICK,     2'd0,      12'd0,    1'b0, '0},
        '{OP_TICK,     2'd0,      12'd0,    1'b1, '{3'd7, MODE_RECORD,   9'd1, 1'b1}},
        '{OP_BUTTON,   2'd0,      12'd0,    1'b1, '{3'd7, MODE_PLAYBACK, 9'd0, 1'b0}},
        '{OP_TICK,     2'd0,      12'd0,    1'b1, '{3'd7, MODE_PLAYBACK, 9'd1, 1'b1}},
        '{OP_TICK,     2'd0,      12'd0,    1'b1, '{3'd0, MODE_PLAYBACK, 9'd2, 1'b1}},
        '{OP_TICK,     2'd0,      12'd0,    1'b1, '{3'd0, MODE_PLAYBACK, 9'd0, 1'b1}},
        '{OP_SAMPLE,   2'd0,      12'd4095, 1'b1, '{3'd0, MODE_PLAYBACK, 9'd0, 1'b0}}
    };

    // random phases: frame lengths 0 and 1, tiny frames, the minimum legal
    // frame run past every width, and the longest frame; ring lengths zero,
    // one, small, full and oversized; positions left over from a longer ring
    phase_t phase_plan [7] = '{
        '{16'd0,     10'd0,    120,  MODE_RECORD,   40, 250, 60},
        '{16'd1,     10'd1023, 150,  MODE_PLAYBACK, 40, 250, 60},
        '{16'd7,     10'd3,    150,  MODE_MANUAL,   30, 250, 60},
        '{16'd4,     10'd512,  150,  MODE_RECORD,   3,  250, 60},
        '{16'd2001,  10'd2,    2400, MODE_RECORD,   2,  40,  10},
        '{16'd65535, 10'd1,    80,   MODE_PLAYBACK, 30, 250, 60},
        '{16'd3,     10'd5,    150,  MODE_RECORD,   40, 250, 60}
    };

    initial
    begin : stimulus
        int unsigned i;
        int unsigned p;
        int unsigned done;
        logic counted;

        // shadow state at reset: centered widths, manual, empty ring
        shadow_ticks    = '0;
        shadow_mode     = MODE_MANUAL;
        shadow_rec_pos  = '0;
        shadow_play_pos = '0;
        shadow_pins     = '0;
        shadow_period   = FRAME_PERIOD_RST;
        shadow_frames   = RECORD_FRAMES_RST;
        for (i = 0; i < NUM_CH; i++)
            shadow_width[i] = WIDTH_CENTER;
        for (i = 0; i < RING_SLOTS; i++)
            shadow_ring[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed items, first at reset timing
        for (i = 0; i < $size(opening_rows); i++)
        begin
            if (i == SHORT_FRAME_ROW)
                set_timing(16'd1, 10'd3);
            idle_sender();
            send_item(opening_rows[i].op, opening_rows[i].ch, opening_rows[i].s,
                      opening_rows[i].known, opening_rows[i].want);
        end

        // random traffic, one timing setting per phase
        for (p = 0; p < $size(phase_plan); p++)
        begin
            set_timing(phase_plan[p].period, phase_plan[p].frames);
            steer_mode(phase_plan[p].start);
            done = 0;
            while (done < phase_plan[p].items)
            begin
                idle_sender();
                send_random(phase_plan[p].btn_pm, phase_plan[p].smp_pm,
                            phase_plan[p].noise_pm, counted);
                if (counted)
                    done++;
            end
        end

        // drain, then give a stray extra result a chance to show up
        in_valid <= 1'b0;
        while (servo_status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
